// ===== design/sbrm_pkg.sv =====
`default_nettype none
package sbrm_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int FILT_W     = 32;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = PROD_W + 4;
  localparam int GAIN_W     = 16;
  localparam int MIX_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DRY_SHIFT  = 12;
  localparam int OUT_SHIFT  = 24;
  localparam int STEP_W     = 5;

  localparam logic [MIX_W-1:0] UNITY     = MIX_W'(4096);
  localparam logic [MIX_W-1:0] MIX_RESET = MIX_W'(2048);
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

  localparam logic CH_L = 1'b0;
  localparam logic CH_R = 1'b1;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GAIN = 3'd5,
    REG_MIX  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    A_B0, A_B1, A_B2, A_A1, A_A2, A_GAIN, A_GM, A_DMIX
  } asel_t;

  typedef enum logic [2:0] {
    B_X, B_X1, B_X2, B_Y1, B_Y2, B_MIX
  } bsel_t;

  typedef enum logic [1:0] {
    FACC_HOLD, FACC_LOAD, FACC_ADD, FACC_SUB
  } facc_op_t;

  typedef enum logic [1:0] {
    MACC_HOLD, MACC_LOAD_DRY, MACC_ADD
  } macc_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT, JMP_GOTO
  } jmp_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_frame_t;

  typedef struct packed {
    logic signed [MUL_W-1:0]  b0;
    logic signed [MUL_W-1:0]  b1;
    logic signed [MUL_W-1:0]  b2;
    logic signed [MUL_W-1:0]  a1;
    logic signed [MUL_W-1:0]  a2;
    logic signed [GAIN_W-1:0] wet_gain;
    logic [MIX_W-1:0]         mix;
  } cfg_t;

  typedef struct packed {
    asel_t    a_sel;
    bsel_t    b_sel;
    logic     mul_ch;
    facc_op_t f_op;
    macc_op_t m_op;
    logic     gm_wr;
    logic     y_wr;
    logic     wb_ch;
    logic     ol_wr;
    jmp_t     jmp;
    step_t    tgt;
  } ctrl_t;

  typedef struct packed {
    ctrl_t uc;
    logic  load_in;
    logic  deliver;
  } dp_ctl_t;

  localparam ctrl_t UC_NOP = '{
    a_sel: A_B0, b_sel: B_X, mul_ch: CH_L, f_op: FACC_HOLD, m_op: MACC_HOLD,
    gm_wr: 1'b0, y_wr: 1'b0, wb_ch: CH_L, ol_wr: 1'b0, jmp: JMP_NEXT, tgt: '0
  };

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = UC_NOP;
    case (step)
      step_t'(0): begin
        c.a_sel = A_GAIN; c.b_sel = B_MIX; c.jmp = JMP_WAIT_IN;
      end
      step_t'(1): begin
        c.gm_wr = 1'b1; c.a_sel = A_B0; c.b_sel = B_X; c.mul_ch = CH_L;
      end
      step_t'(2): begin
        c.f_op = FACC_LOAD; c.a_sel = A_B1; c.b_sel = B_X1; c.mul_ch = CH_L;
      end
      step_t'(3): begin
        c.f_op = FACC_ADD; c.a_sel = A_B2; c.b_sel = B_X2; c.mul_ch = CH_L;
      end
      step_t'(4): begin
        c.f_op = FACC_ADD; c.a_sel = A_A1; c.b_sel = B_Y1; c.mul_ch = CH_L;
      end
      step_t'(5): begin
        c.f_op = FACC_SUB; c.a_sel = A_A2; c.b_sel = B_Y2; c.mul_ch = CH_L;
      end
      step_t'(6): begin
        c.f_op = FACC_SUB; c.a_sel = A_DMIX; c.b_sel = B_X; c.mul_ch = CH_L;
      end
      step_t'(7): begin
        c.y_wr = 1'b1; c.wb_ch = CH_L; c.m_op = MACC_LOAD_DRY;
        c.a_sel = A_B0; c.b_sel = B_X; c.mul_ch = CH_R;
      end
      step_t'(8): begin
        c.f_op = FACC_LOAD; c.a_sel = A_GM; c.b_sel = B_Y1; c.mul_ch = CH_L;
      end
      step_t'(9): begin
        c.m_op = MACC_ADD; c.a_sel = A_B1; c.b_sel = B_X1; c.mul_ch = CH_R;
      end
      step_t'(10): begin
        c.ol_wr = 1'b1; c.f_op = FACC_ADD;
        c.a_sel = A_B2; c.b_sel = B_X2; c.mul_ch = CH_R;
      end
      step_t'(11): begin
        c.f_op = FACC_ADD; c.a_sel = A_A1; c.b_sel = B_Y1; c.mul_ch = CH_R;
      end
      step_t'(12): begin
        c.f_op = FACC_SUB; c.a_sel = A_A2; c.b_sel = B_Y2; c.mul_ch = CH_R;
      end
      step_t'(13): begin
        c.f_op = FACC_SUB; c.a_sel = A_DMIX; c.b_sel = B_X; c.mul_ch = CH_R;
      end
      step_t'(14): begin
        c.y_wr = 1'b1; c.wb_ch = CH_R; c.m_op = MACC_LOAD_DRY;
      end
      step_t'(15): begin
        c.a_sel = A_GM; c.b_sel = B_Y1; c.mul_ch = CH_R;
      end
      step_t'(16): begin
        c.m_op = MACC_ADD;
      end
      step_t'(17): begin
        c.jmp = JMP_WAIT_OUT; c.tgt = '0;
      end
      default: begin
        c.jmp = JMP_GOTO; c.tgt = '0;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/sbrm_cfg_regs.sv =====
`default_nettype none
module sbrm_cfg_regs #(
  parameter int COEF_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sbrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sbrm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sbrm_pkg::cfg_t                         cfg
);

  logic signed [COEF_WIDTH-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [sbrm_pkg::GAIN_W-1:0] gain_r;
  logic [sbrm_pkg::MIX_W-1:0] mix_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r   <= '0;
      b1_r   <= '0;
      b2_r   <= '0;
      a1_r   <= '0;
      a2_r   <= '0;
      gain_r <= sbrm_pkg::GAIN_RESET;
      mix_r  <= sbrm_pkg::MIX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sbrm_pkg::REG_B0:   b0_r   <= cfg_data[COEF_WIDTH-1:0];
        sbrm_pkg::REG_B1:   b1_r   <= cfg_data[COEF_WIDTH-1:0];
        sbrm_pkg::REG_B2:   b2_r   <= cfg_data[COEF_WIDTH-1:0];
        sbrm_pkg::REG_A1:   a1_r   <= cfg_data[COEF_WIDTH-1:0];
        sbrm_pkg::REG_A2:   a2_r   <= cfg_data[COEF_WIDTH-1:0];
        sbrm_pkg::REG_GAIN: gain_r <= cfg_data[sbrm_pkg::GAIN_W-1:0];
        sbrm_pkg::REG_MIX:  mix_r  <= cfg_data[sbrm_pkg::MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.b0       = sbrm_pkg::MUL_W'(b0_r);
    cfg.b1       = sbrm_pkg::MUL_W'(b1_r);
    cfg.b2       = sbrm_pkg::MUL_W'(b2_r);
    cfg.a1       = sbrm_pkg::MUL_W'(a1_r);
    cfg.a2       = sbrm_pkg::MUL_W'(a2_r);
    cfg.wet_gain = gain_r;
    cfg.mix      = mix_r;
  end

endmodule
`default_nettype wire

// ===== design/sbrm_sequencer.sv =====
`default_nettype none
module sbrm_sequencer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sbrm_pkg::dp_ctl_t  ctl
);

  sbrm_pkg::step_t step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;
  sbrm_pkg::ctrl_t uc;
  logic            in_fire;
  logic            out_free;

  assign uc        = sbrm_pkg::ucode(step_r);
  assign in_ready  = (uc.jmp == sbrm_pkg::JMP_WAIT_IN);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    ctl.uc      = uc;
    ctl.load_in = in_fire;
    ctl.deliver = (uc.jmp == sbrm_pkg::JMP_WAIT_OUT) && out_free;
  end

  always_comb begin
    case (uc.jmp)
      sbrm_pkg::JMP_NEXT:     step_nxt = step_r + sbrm_pkg::STEP_W'(1);
      sbrm_pkg::JMP_WAIT_IN:  step_nxt = in_fire ? step_r + sbrm_pkg::STEP_W'(1) : step_r;
      sbrm_pkg::JMP_WAIT_OUT: step_nxt = out_free ? uc.tgt : step_r;
      sbrm_pkg::JMP_GOTO:     step_nxt = uc.tgt;
      default:                step_nxt = '0;
    endcase
    if (ctl.deliver) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/sbrm_datapath.sv =====
`default_nettype none
module sbrm_datapath #(
  parameter int COEF_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sbrm_pkg::cfg_t       cfg,
  input  wire sbrm_pkg::dp_ctl_t    ctl,
  input  wire sbrm_pkg::in_frame_t  in_data,
  output sbrm_pkg::out_frame_t      out_data
);

  localparam int SW = sbrm_pkg::SAMPLE_W;
  localparam int FW = sbrm_pkg::FILT_W;
  localparam int MW = sbrm_pkg::MUL_W;
  localparam int AW = sbrm_pkg::ACC_W;
  localparam int CF = COEF_WIDTH - 2;

  localparam logic signed [AW-1:0] F_HALF = AW'(1) << (CF - 1);
  localparam logic signed [AW-1:0] M_HALF = AW'(1) << (sbrm_pkg::OUT_SHIFT - 1);
  localparam logic signed [FW-1:0] F_MAX  = {1'b0, {(FW-1){1'b1}}};
  localparam logic signed [FW-1:0] F_MIN  = {1'b1, {(FW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX  = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN  = {1'b1, {(SW-1){1'b0}}};

  logic signed [SW-1:0] x_r  [2];
  logic signed [SW-1:0] x1_r [2];
  logic signed [SW-1:0] x2_r [2];
  logic signed [FW-1:0] y1_r [2];
  logic signed [FW-1:0] y2_r [2];

  logic signed [sbrm_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [MW-1:0]               gm_r;
  logic signed [AW-1:0]               acc_f_r, acc_f_nxt;
  logic signed [AW-1:0]               acc_m_r, acc_m_nxt;
  logic signed [SW-1:0]               ol_r;
  sbrm_pkg::out_frame_t               out_r;

  logic [sbrm_pkg::MIX_W-1:0] mix_c, dmix;
  logic signed [MW-1:0]       op_a, op_b;
  logic signed [AW-1:0]       p_ext, p_dry;
  logic signed [AW-1:0]       f_sh, m_sh;
  logic [AW-FW:0]             f_hi;
  logic [AW-SW:0]             m_hi;
  logic signed [FW-1:0]       y_new;
  logic signed [SW-1:0]       mix_out;
  logic                       ch;

  assign ch    = ctl.uc.mul_ch;
  assign mix_c = (cfg.mix > sbrm_pkg::UNITY) ? sbrm_pkg::UNITY : cfg.mix;
  assign dmix  = sbrm_pkg::UNITY - mix_c;

  always_comb begin
    case (ctl.uc.a_sel)
      sbrm_pkg::A_B0:   op_a = cfg.b0;
      sbrm_pkg::A_B1:   op_a = cfg.b1;
      sbrm_pkg::A_B2:   op_a = cfg.b2;
      sbrm_pkg::A_A1:   op_a = cfg.a1;
      sbrm_pkg::A_A2:   op_a = cfg.a2;
      sbrm_pkg::A_GAIN: op_a = MW'(cfg.wet_gain);
      sbrm_pkg::A_GM:   op_a = gm_r;
      sbrm_pkg::A_DMIX: op_a = {{(MW-sbrm_pkg::MIX_W){1'b0}}, dmix};
      default:          op_a = '0;
    endcase
    case (ctl.uc.b_sel)
      sbrm_pkg::B_X:   op_b = MW'(x_r[ch]);
      sbrm_pkg::B_X1:  op_b = MW'(x1_r[ch]);
      sbrm_pkg::B_X2:  op_b = MW'(x2_r[ch]);
      sbrm_pkg::B_Y1:  op_b = MW'(y1_r[ch]);
      sbrm_pkg::B_Y2:  op_b = MW'(y2_r[ch]);
      sbrm_pkg::B_MIX: op_b = {{(MW-sbrm_pkg::MIX_W){1'b0}}, mix_c};
      default:         op_b = '0;
    endcase
    prod_nxt = op_a * op_b;
  end

  assign p_ext = AW'(prod_r);
  assign p_dry = p_ext <<< sbrm_pkg::DRY_SHIFT;

  always_comb begin
    case (ctl.uc.f_op)
      sbrm_pkg::FACC_LOAD: acc_f_nxt = p_ext;
      sbrm_pkg::FACC_ADD:  acc_f_nxt = acc_f_r + p_ext;
      sbrm_pkg::FACC_SUB:  acc_f_nxt = acc_f_r - p_ext;
      default:             acc_f_nxt = acc_f_r;
    endcase
    case (ctl.uc.m_op)
      sbrm_pkg::MACC_LOAD_DRY: acc_m_nxt = p_dry;
      sbrm_pkg::MACC_ADD:      acc_m_nxt = acc_m_r + p_ext;
      default:                 acc_m_nxt = acc_m_r;
    endcase
  end

  always_comb begin
    f_sh = (acc_f_r + F_HALF) >>> CF;
    f_hi = f_sh[AW-1:FW-1];
    if ((&f_hi) || !(|f_hi)) begin
      y_new = f_sh[FW-1:0];
    end else begin
      y_new = f_sh[AW-1] ? F_MIN : F_MAX;
    end
    m_sh = (acc_m_r + M_HALF) >>> sbrm_pkg::OUT_SHIFT;
    m_hi = m_sh[AW-1:SW-1];
    if ((&m_hi) || !(|m_hi)) begin
      mix_out = m_sh[SW-1:0];
    end else begin
      mix_out = m_sh[AW-1] ? S_MIN : S_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        x1_r[i] <= '0;
        x2_r[i] <= '0;
        y1_r[i] <= '0;
        y2_r[i] <= '0;
      end
    end else if (ctl.uc.y_wr) begin
      x2_r[ctl.uc.wb_ch] <= x1_r[ctl.uc.wb_ch];
      x1_r[ctl.uc.wb_ch] <= x_r[ctl.uc.wb_ch];
      y2_r[ctl.uc.wb_ch] <= y1_r[ctl.uc.wb_ch];
      y1_r[ctl.uc.wb_ch] <= y_new;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    acc_f_r <= acc_f_nxt;
    acc_m_r <= acc_m_nxt;
    if (ctl.load_in) begin
      x_r[sbrm_pkg::CH_L] <= in_data.left_in;
      x_r[sbrm_pkg::CH_R] <= in_data.right_in;
    end
    if (ctl.uc.gm_wr) begin
      gm_r <= prod_r[MW-1:0];
    end
    if (ctl.uc.ol_wr) begin
      ol_r <= mix_out;
    end
    if (ctl.deliver) begin
      out_r.left_out  <= ol_r;
      out_r.right_out <= mix_out;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// ===== design/stereo_biquad_resonator_mix.sv =====
`default_nettype none
// Channel  Ports                                      Payload
// in       in_valid / in_ready / in_data              left_in, right_in (Q1.23)
// out      out_valid / out_ready / out_data           left_out, right_out (Q1.23)
// cfg      cfg_valid / cfg_ready / cfg_index,cfg_data register index, write data
//
// A single 32x32 multiplier issues one gain product and seven products per channel,
// stepped by the microcode table.
// in_ready is high only at the first step; the frame is captured on transfer.
// Reset clears filter history to zero and loads register defaults.
// A finished frame waits in the result register; the sequencer holds at its last
// step while that register is occupied and not read, so no next frame is taken meanwhile.
module stereo_biquad_resonator_mix #(
  parameter int COEF_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire sbrm_pkg::in_frame_t             in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output sbrm_pkg::out_frame_t                 out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sbrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sbrm_pkg::CFG_DATA_W-1:0] cfg_data
);

  sbrm_pkg::cfg_t    cfg;
  sbrm_pkg::dp_ctl_t ctl;

  sbrm_cfg_regs #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sbrm_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  sbrm_datapath #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .ctl      (ctl),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/sbrm_frame_compare.sv =====
`timescale 1ns / 1ps
module sbrm_frame_compare
  import sbrm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  in_frame_t                  in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  out_frame_t                 out_data,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         frames_due
);

  localparam int FRAC_BITS  = 30;

  typedef logic signed [71:0] wide_t;

  logic signed [MUL_W-1:0]    b0, b1, b2, a1, a2;
  logic signed [GAIN_W-1:0]   wet_gain;
  logic [MIX_W-1:0]           wet_mix;
  logic signed [SAMPLE_W-1:0] dry_hist [2][2];
  logic signed [FILT_W-1:0]   filt_hist [2][2];
  out_frame_t                 predicted_mixes [$];

  task automatic report(string what);
    mismatches = mismatches + 1;
    $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  function automatic wide_t clamp(wide_t v, int w);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] filter_and_blend(
    logic ch, logic signed [SAMPLE_W-1:0] x);
    wide_t sum, blend;
    logic signed [FILT_W-1:0] y;
    logic [MIX_W-1:0] m;
    sum = wide_t'(b0) * wide_t'(x)
        + wide_t'(b1) * wide_t'(dry_hist[ch][0])
        + wide_t'(b2) * wide_t'(dry_hist[ch][1])
        - wide_t'(a1) * wide_t'(filt_hist[ch][0])
        - wide_t'(a2) * wide_t'(filt_hist[ch][1]);
    sum = (sum + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    y = FILT_W'(clamp(sum, FILT_W));
    dry_hist[ch][1]  = dry_hist[ch][0];
    dry_hist[ch][0]  = x;
    filt_hist[ch][1] = filt_hist[ch][0];
    filt_hist[ch][0] = y;
    m = (wet_mix > UNITY) ? UNITY : wet_mix;
    blend = (wide_t'(x) <<< DRY_SHIFT) * (wide_t'(UNITY) - wide_t'(m))
          + wide_t'(y) * wide_t'(wet_gain) * wide_t'(m);
    blend = (blend + (wide_t'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    return SAMPLE_W'(clamp(blend, SAMPLE_W));
  endfunction

  function automatic out_frame_t predict_mix(in_frame_t f);
    out_frame_t r;
    r.left_out  = filter_and_blend(CH_L, f.left_in);
    r.right_out = filter_and_blend(CH_R, f.right_in);
    return r;
  endfunction

  task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
    case (idx)
      REG_B0:   b0 = word[MUL_W-1:0];
      REG_B1:   b1 = word[MUL_W-1:0];
      REG_B2:   b2 = word[MUL_W-1:0];
      REG_A1:   a1 = word[MUL_W-1:0];
      REG_A2:   a2 = word[MUL_W-1:0];
      REG_GAIN: wet_gain = word[GAIN_W-1:0];
      REG_MIX:  wet_mix = word[MIX_W-1:0];
      default:  ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_frame_t want;
    if (!rst_n) begin
      b0 = '0;
      b1 = '0;
      b2 = '0;
      a1 = '0;
      a2 = '0;
      wet_gain = GAIN_RESET;
      wet_mix = MIX_RESET;
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < 2; k++) begin
          dry_hist[c][k]  = '0;
          filt_hist[c][k] = '0;
        end
      end
      predicted_mixes.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready) predicted_mixes.push_back(predict_mix(in_data));
      if (out_valid && out_ready) begin
        if (predicted_mixes.size() == 0) begin
          report($sformatf("result transfer with none outstanding: left %0d right %0d",
                           out_data.left_out, out_data.right_out));
        end else begin
          want = predicted_mixes.pop_front();
          if (out_data.left_out !== want.left_out) begin
            report($sformatf("left_out got %0d want %0d",
                             out_data.left_out, want.left_out));
          end
          if (out_data.right_out !== want.right_out) begin
            report($sformatf("right_out got %0d want %0d",
                             out_data.right_out, want.right_out));
          end
        end
      end
    end
    frames_due <= predicted_mixes.size();
  end

endmodule

// ===== tb/stereo_biquad_resonator_mix_tb.sv =====
`timescale 1ns / 1ps
module stereo_biquad_resonator_mix_tb;
  import sbrm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
  localparam logic [MUL_W-1:0] COEF_MAX   = 32'h7FFF_FFFF;
  localparam logic [MUL_W-1:0] COEF_MIN   = 32'h8000_0000;
  localparam logic [MUL_W-1:0] COEF_UNITY = 32'h4000_0000;
  localparam logic [GAIN_W-1:0] GAIN_MAX  = 16'h7FFF;
  localparam logic [GAIN_W-1:0] GAIN_MIN  = 16'h8000;
  localparam logic [MIX_W-1:0] MIX_TOP    = 13'h1FFF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES = 8;
  localparam int PHASE_FRAMES = 200;
  localparam int TAIL_CYCLES = 40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_frame_t             in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_frame_t            out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    frames_due;
  int                    send_idle_max = 0;
  int                    recv_idle_max = 0;
  bit                    hold_off_req = 1'b0;

  wire moved = (in_valid && in_ready) || (out_valid && out_ready) ||
               (cfg_valid && cfg_ready);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stereo_biquad_resonator_mix DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sbrm_frame_compare mix_compare (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .frames_due (frames_due)
  );

  function automatic in_frame_t frame(logic signed [SAMPLE_W-1:0] l,
                                      logic signed [SAMPLE_W-1:0] r);
    in_frame_t f;
    f.left_in  = l;
    f.right_in = r;
    return f;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return SAMPLE_W'($urandom_range(0, 511)) - SAMPLE_W'(256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [MUL_W-1:0] rand_coef(bit gentle);
    if (gentle) return MUL_W'($urandom_range(0, 32'h4000_0000)) - MUL_W'(32'h2000_0000);
    case ($urandom_range(0, 5))
      0: return COEF_MIN;
      1: return COEF_MAX;
      2: return '0;
      default: return MUL_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return GAIN_MIN;
      1: return GAIN_MAX;
      2: return GAIN_W'(GAIN_RESET);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [MIX_W-1:0] rand_mix();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return UNITY;
      2: return MIX_TOP;
      3: return UNITY + MIX_W'(1);
      default: return MIX_W'($urandom_range(0, 4096));
    endcase
  endfunction

  task automatic send_frame(in_frame_t f);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // upper data bits of the narrow registers carry noise
  task automatic load_settings(logic [MUL_W-1:0] c_b0, logic [MUL_W-1:0] c_b1,
                               logic [MUL_W-1:0] c_b2, logic [MUL_W-1:0] c_a1,
                               logic [MUL_W-1:0] c_a2, logic [GAIN_W-1:0] gain,
                               logic [MIX_W-1:0] mix);
    write_reg(REG_B0, c_b0);
    write_reg(REG_B1, c_b1);
    write_reg(REG_B2, c_b2);
    write_reg(REG_A1, c_a1);
    write_reg(REG_A2, c_a2);
    write_reg(REG_GAIN, {16'($urandom), gain});
    write_reg(REG_MIX, {19'($urandom), mix});
    write_reg(REG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      stall = $urandom_range(0, recv_idle_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (moved) stalled = 0;
      else stalled++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    bit gentle;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: half dry, filter silent
    send_frame(frame(SAMPLE_MAX, SAMPLE_MIN));
    send_frame(frame(SAMPLE_MIN, SAMPLE_MAX));
    send_frame(frame('0, -24'sd1));
    send_frame(frame(24'sd1, '0));
    send_frame(frame(24'shAAAAAA, 24'sh555555));
    drain();

    // unity pass-through, fully wet
    load_settings(COEF_UNITY, '0, '0, '0, '0, GAIN_W'(GAIN_RESET), UNITY);
    send_frame(frame(SAMPLE_MAX, SAMPLE_MIN));
    send_frame(frame(SAMPLE_MIN, SAMPLE_MAX));
    send_frame(frame(24'sh555555, 24'shAAAAAA));
    drain();

    // runaway feedback: filter and output both saturate, mix above unity
    load_settings(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, GAIN_MAX, MIX_TOP);
    repeat (4) send_frame(frame(SAMPLE_MAX, SAMPLE_MIN));
    repeat (2) send_frame(frame('0, '0));
    drain();

    load_settings(COEF_MIN, '0, '0, '0, '0, GAIN_MIN, UNITY + MIX_W'(1));
    send_frame(frame(SAMPLE_MAX, SAMPLE_MIN));
    send_frame(frame(SAMPLE_MIN, SAMPLE_MAX));
    send_frame(frame(24'sd1, -24'sd1));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      gentle = (p % 3 == 1);
      if (p % 3 == 2) begin
        // narrow band-pass near fs/16, high Q
        load_settings(32'sd20154000, '0, -32'sd20154000, -32'sd1946800000,
                      32'sd1033434000, rand_gain(), rand_mix());
      end else begin
        load_settings(rand_coef(gentle), rand_coef(gentle), rand_coef(gentle),
                      rand_coef(gentle), rand_coef(gentle), rand_gain(), rand_mix());
      end
      send_idle_max = (p % 2 == 1) ? 19 : 0;
      recv_idle_max = (p % 4 >= 2) ? 19 : 0;
      if (p == 4) hold_off_req = 1'b1;
      for (int i = 0; i < PHASE_FRAMES; i++) begin
        send_frame(frame(rand_sample(), rand_sample()));
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && frames_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
